// ===== design/tlc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tlc_pkg;

    // Cache geometry: two ways, set index taken from the low address bits.
    localparam int NumSets     = 16;
    localparam int SetBits     = $clog2(NumSets);
    localparam int DefAddrBits = 32;

    // Stream payload widths.
    localparam int InAddrW  = 32;
    localparam int CountW   = 32;
    localparam int OutBits  = 2 + 2 * CountW;
    localparam int OutDataW = ((OutBits + 7) / 8) * 8;

    // Controller states, one-hot.
    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_LOOKUP = 2'b10
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic commit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/two_way_lru_cache_tag_lookup_core.sv =====
// An accepted address item is registered; its tag compare, set update and output load
// then happen together once the output register is free, and the result is registered.
// A new address item is not taken while a lookup is pending.
// A result waiting on the output holds the next lookup, and the input stays not ready
// until that lookup can load its result.
// Reset (synchronous, active low) clears valid bits, LRU bits, counts and handshakes.
`timescale 1ns / 1ps
`default_nettype none

module two_way_lru_cache_tag_lookup_core
    import tlc_pkg::*;
#(
    parameter int ADDR_BITS = DefAddrBits
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // tdata: address[31:0]
    input  wire logic [InAddrW-1:0]  i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // tdata: hit[0], way_used[1], hit_count[33:2], access_count[65:34], zero pad
    output logic [OutDataW-1:0]      o_m_axis_tdata
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    // Sequencing.
    tlc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Tag store, compare and counters.
    tlc_datapath #(
        .ADDR_BITS (ADDR_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_addr      (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

    // No second item is taken straight after one.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted while a lookup is pending");

    // A load and a commit never coincide.
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_cmd.load_in && w_cmd.commit))
        else $error("load and commit in the same cycle");

    // Hits never outnumber accesses.
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[65:34] >= o_m_axis_tdata[33:2]))
        else $error("hit count above access count");

    // A reported hit has a nonzero hit count.
    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[0]) |-> (o_m_axis_tdata[33:2] != '0))
        else $error("hit reported with zero hit count");

endmodule

`default_nettype wire

// ===== design/tlc_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlc_ctrl
    import tlc_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    // An item is taken only when no lookup is pending.
    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_cmd.load_in = (r_state == ST_IDLE) && i_in_valid;
    assign o_cmd.commit  = (r_state == ST_LOOKUP) && i_status.out_free;

    // Next state: the lookup commits once the output register can take its result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/tlc_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tlc_datapath
    import tlc_pkg::*;
#(
    parameter int ADDR_BITS = DefAddrBits
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire t_dp_cmd             i_cmd,
    output t_dp_status               o_status,
    input  wire logic [InAddrW-1:0]  i_addr,
    input  wire logic                i_out_ready,
    output logic                     o_out_valid,
    output logic [OutDataW-1:0]      o_out_data
);

    localparam int EffBits = (ADDR_BITS < InAddrW) ? ADDR_BITS : InAddrW;
    localparam int TagW    = EffBits - SetBits;
    localparam int PadW    = OutDataW - OutBits;

    // Address of the pending lookup.
    logic [EffBits-1:0] r_addr;

    // Tag store, one array per way, plus valid and LRU bits per set.
    logic [TagW-1:0]    r_tag0 [NumSets];
    logic [TagW-1:0]    r_tag1 [NumSets];
    logic [NumSets-1:0] r_valid0;
    logic [NumSets-1:0] r_valid1;
    logic [NumSets-1:0] r_lru;

    // Running counts and the output register.
    logic [CountW-1:0]  r_hits;
    logic [CountW-1:0]  r_acc;
    logic [CountW-1:0]  n_hits;
    logic [CountW-1:0]  n_acc;
    logic               r_out_valid;
    logic               r_out_hit;
    logic               r_out_way;

    logic [SetBits-1:0] w_set;
    logic [TagW-1:0]    w_tag;
    logic               w_hit0;
    logic               w_hit1;
    logic               w_hit;
    logic               w_way;

    // Split the address into set index and tag.
    assign w_set = r_addr[SetBits-1:0];
    assign w_tag = r_addr[EffBits-1:SetBits];

    // Compare both ways of the set and pick the way that hits or is refilled.
    always_comb begin
        w_hit0 = r_valid0[w_set] && (r_tag0[w_set] == w_tag);
        w_hit1 = r_valid1[w_set] && (r_tag1[w_set] == w_tag);
        w_hit  = w_hit0 || w_hit1;
        if (w_hit0) begin
            w_way = 1'b0;
        end else if (w_hit1) begin
            w_way = 1'b1;
        end else if (!r_valid0[w_set]) begin
            w_way = 1'b0;
        end else if (!r_valid1[w_set]) begin
            w_way = 1'b1;
        end else begin
            w_way = r_lru[w_set];
        end
    end

    // Saturating counters.
    always_comb begin
        n_hits = r_hits;
        if (w_hit && (r_hits != {CountW{1'b1}})) begin
            n_hits = r_hits + 1'b1;
        end
        n_acc = r_acc;
        if (r_acc != {CountW{1'b1}}) begin
            n_acc = r_acc + 1'b1;
        end
    end

    // Address capture, tag writes and output hit and way, no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_addr <= i_addr[EffBits-1:0];
        end
        if (i_cmd.commit && !w_hit) begin
            if (w_way) begin
                r_tag1[w_set] <= w_tag;
            end else begin
                r_tag0[w_set] <= w_tag;
            end
        end
        if (i_cmd.commit) begin
            r_out_hit <= w_hit;
            r_out_way <= w_way;
        end
    end

    // Valid bits, LRU bits, counters and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0    <= '0;
            r_valid1    <= '0;
            r_lru       <= '0;
            r_hits      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                if (!w_hit) begin
                    if (w_way) begin
                        r_valid1[w_set] <= 1'b1;
                    end else begin
                        r_valid0[w_set] <= 1'b1;
                    end
                end
                r_lru[w_set] <= ~w_way;
                r_hits       <= n_hits;
                r_acc        <= n_acc;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = {{PadW{1'b0}}, r_acc, r_hits, r_out_way, r_out_hit};

endmodule

`default_nettype wire
